// ----- rtl/wtgt_pkg.sv -----
package wtgt_pkg;

   localparam int CordicSteps = 16;
   localparam int FracBits = 8;
   localparam int HalfTurn = 18000;
   localparam int FullTurn = 36000;
   localparam int QuarterTurn = 9000;
   localparam int AngScale = 65536;

   // vector width: speed 14 bits << 8, cordic gain < 1.65, sum of two, sign
   localparam int VecW = 26;
   // angle width: +-180 deg in 1/(100*65536) deg, with headroom
   localparam int AngW = 33;

   localparam logic [1:0] CsrAddrMinGs = 2'd0;

   typedef logic signed [VecW-1:0] vec_type;
   typedef logic signed [AngW-1:0] ang_type;

   typedef struct packed {
      logic valid;
      logic bypass;
      logic [15:0] heading;
      vec_type x;
      vec_type y;
      ang_type z;
      vec_type wx;
      vec_type wy;
      ang_type wz;
   } rot_stage_type;

   typedef struct packed {
      logic valid;
      logic bypass;
      logic zero;
      logic [15:0] heading;
      vec_type x;
      vec_type y;
      ang_type z;
   } vct_stage_type;

   function automatic ang_type atan_entry(input int i);
      ang_type r;
      case (i)
         0: r = 33'sd294912000;
         1: r = 33'sd174096719;
         2: r = 33'sd91987925;
         3: r = 33'sd46694507;
         4: r = 33'sd23437865;
         5: r = 33'sd11730358;
         6: r = 33'sd5866610;
         7: r = 33'sd2933484;
         8: r = 33'sd1466764;
         9: r = 33'sd733385;
         10: r = 33'sd366693;
         11: r = 33'sd183346;
         12: r = 33'sd91673;
         13: r = 33'sd45837;
         14: r = 33'sd22918;
         15: r = 33'sd11459;
         16: r = 33'sd5730;
         17: r = 33'sd2865;
         18: r = 33'sd1432;
         19: r = 33'sd716;
         20: r = 33'sd358;
         21: r = 33'sd179;
         22: r = 33'sd90;
         23: r = 33'sd45;
         default: r = '0;
      endcase
      return r;
   endfunction

   // modulo 36000 of a 16 bit value: at most one subtract
   function automatic logic [15:0] wrap_angle(input logic [15:0] a);
      logic [15:0] r;
      r = (a >= 16'(FullTurn)) ? a - 16'(FullTurn) : a;
      return r;
   endfunction

   // fold angle (0..35999) into +-90 deg, return start x sign flip
   function automatic void fold_angle(input logic [15:0] a, output logic neg,
         output ang_type z);
      logic signed [17:0] s;
      s = $signed({2'b00, a});
      if (s > 18'sd18000) begin
         s = s - 18'sd36000;
      end
      neg = 1'b0;
      if (s > 18'sd9000) begin
         neg = 1'b1;
         s = s - 18'sd18000;
      end else if (s < -18'sd9000) begin
         neg = 1'b1;
         s = s + 18'sd18000;
      end
      z = AngW'(s) <<< 16;
   endfunction

endpackage

// ----- rtl/wind_triangle_ground_track.sv -----
// Ground track from heading, airspeed and wind. One word is accepted every cycle while
// the output register is empty or rsp_tready is high. The stages are an input stage that
// wraps and folds the angles, a rotation CORDIC pipeline (both vectors side by side, one
// step per stage), a sum stage, a vectoring CORDIC pipeline and the output register, with
// the rounding in front of it. The whole pipeline advances together and holds when the
// output word is not taken. Register min_ground_speed sits at byte address 0; below it
// the heading is returned.
module wind_triangle_ground_track (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // true_heading[15:0], wind_direction[31:16], wind_speed[43:32],
   // true_airspeed[57:44], ground_speed[71:58]
   input  logic [71:0] req_tdata,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   // ground_track[15:0]
   output logic [15:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [13:0] min_gs_ff;
   logic advance;
   wtgt_pkg::rot_stage_type rot_in_in, rot_in_ff, rot_out;
   wtgt_pkg::vct_stage_type vct_in_ff, vct_in_in, vct_out;
   logic rsp_valid_ff;
   logic [15:0] rsp_data_ff;
   logic [15:0] track_in;

   assign csr_pready = 1'b1;
   assign csr_prdata = {18'd0, min_gs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         min_gs_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite
            && csr_paddr == wtgt_pkg::CsrAddrMinGs) begin
         min_gs_ff <= csr_pwdata[13:0];
      end
   end

   assign advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      logic [15:0] hd, wd, wd2;
      logic [16:0] wsum;
      logic na, nw;
      wtgt_pkg::ang_type za, zw;
      wtgt_pkg::vec_type sa, sw;
      hd = wtgt_pkg::wrap_angle(req_tdata[15:0]);
      wd = wtgt_pkg::wrap_angle(req_tdata[31:16]);
      wsum = {1'b0, wd} + 17'd18000;
      wd2 = (wsum >= 17'd36000) ? 16'(wsum - 17'd36000) : wsum[15:0];
      wtgt_pkg::fold_angle(hd, na, za);
      wtgt_pkg::fold_angle(wd2, nw, zw);
      sa = wtgt_pkg::VecW'({req_tdata[57:44], 8'd0});
      sw = wtgt_pkg::VecW'({req_tdata[43:32], 8'd0});
      rot_in_in.valid = req_tvalid;
      rot_in_in.bypass = req_tdata[71:58] < min_gs_ff;
      rot_in_in.heading = hd;
      rot_in_in.x = na ? -sa : sa;
      rot_in_in.y = '0;
      rot_in_in.z = za;
      rot_in_in.wx = nw ? -sw : sw;
      rot_in_in.wy = '0;
      rot_in_in.wz = zw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_in_ff.valid <= 1'b0;
      end else if (advance) begin
         rot_in_ff <= rot_in_in;
      end
   end

   wtgt_rotate u_rotate (
      .clock(clock), .reset(reset), .advance(advance),
      .stage_in(rot_in_ff), .stage_out(rot_out)
   );

   always_comb begin
      wtgt_pkg::vec_type n, e;
      n = rot_out.x + rot_out.wx;
      e = rot_out.y + rot_out.wy;
      vct_in_in.valid = rot_out.valid;
      vct_in_in.bypass = rot_out.bypass;
      vct_in_in.heading = rot_out.heading;
      vct_in_in.zero = (n == 0) && (e == 0);
      if (n < 0) begin
         vct_in_in.x = -n;
         vct_in_in.y = -e;
         vct_in_in.z = wtgt_pkg::AngW'(64'(wtgt_pkg::HalfTurn) * wtgt_pkg::AngScale);
      end else begin
         vct_in_in.x = n;
         vct_in_in.y = e;
         vct_in_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vct_in_ff.valid <= 1'b0;
      end else if (advance) begin
         vct_in_ff <= vct_in_in;
      end
   end

   wtgt_vector u_vector (
      .clock(clock), .reset(reset), .advance(advance),
      .stage_in(vct_in_ff), .stage_out(vct_out)
   );

   always_comb begin
      wtgt_pkg::ang_type zr;
      logic signed [16:0] r;
      zr = vct_out.z + wtgt_pkg::AngW'(wtgt_pkg::AngScale / 2);
      r = zr[32:16];
      if (r < 0) begin
         r = r + 17'sd36000;
      end else if (r >= 17'sd36000) begin
         r = r - 17'sd36000;
      end
      if (vct_out.bypass) begin
         track_in = vct_out.heading;
      end else if (vct_out.zero) begin
         track_in = '0;
      end else begin
         track_in = r[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vct_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= track_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_track_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff < 16'd36000) else $error("track out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("output word lost on stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready) else $error("stall without pending word");

endmodule

// ----- rtl/wtgt_rotate.sv -----
module wtgt_rotate (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  wtgt_pkg::rot_stage_type stage_in,
   output wtgt_pkg::rot_stage_type stage_out
);

   wtgt_pkg::rot_stage_type pipe_ff [wtgt_pkg::CordicSteps];
   wtgt_pkg::rot_stage_type pipe_in [wtgt_pkg::CordicSteps];

   always_comb begin
      for (int i = 0; i < wtgt_pkg::CordicSteps; i++) begin
         wtgt_pkg::rot_stage_type s;
         s = (i == 0) ? stage_in : pipe_ff[i-1];
         pipe_in[i] = s;
         if (s.z >= 0) begin
            pipe_in[i].x = s.x - (s.y >>> i);
            pipe_in[i].y = s.y + (s.x >>> i);
            pipe_in[i].z = s.z - wtgt_pkg::atan_entry(i);
         end else begin
            pipe_in[i].x = s.x + (s.y >>> i);
            pipe_in[i].y = s.y - (s.x >>> i);
            pipe_in[i].z = s.z + wtgt_pkg::atan_entry(i);
         end
         if (s.wz >= 0) begin
            pipe_in[i].wx = s.wx - (s.wy >>> i);
            pipe_in[i].wy = s.wy + (s.wx >>> i);
            pipe_in[i].wz = s.wz - wtgt_pkg::atan_entry(i);
         end else begin
            pipe_in[i].wx = s.wx + (s.wy >>> i);
            pipe_in[i].wy = s.wy - (s.wx >>> i);
            pipe_in[i].wz = s.wz + wtgt_pkg::atan_entry(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < wtgt_pkg::CordicSteps; i++) begin
         if (reset) begin
            pipe_ff[i].valid <= 1'b0;
         end else if (advance) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   assign stage_out = pipe_ff[wtgt_pkg::CordicSteps-1];

endmodule

// ----- rtl/wtgt_vector.sv -----
module wtgt_vector (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  wtgt_pkg::vct_stage_type stage_in,
   output wtgt_pkg::vct_stage_type stage_out
);

   wtgt_pkg::vct_stage_type pipe_ff [wtgt_pkg::CordicSteps];
   wtgt_pkg::vct_stage_type pipe_in [wtgt_pkg::CordicSteps];

   always_comb begin
      for (int i = 0; i < wtgt_pkg::CordicSteps; i++) begin
         wtgt_pkg::vct_stage_type s;
         s = (i == 0) ? stage_in : pipe_ff[i-1];
         pipe_in[i] = s;
         if (s.y < 0) begin
            pipe_in[i].x = s.x - (s.y >>> i);
            pipe_in[i].y = s.y + (s.x >>> i);
            pipe_in[i].z = s.z - wtgt_pkg::atan_entry(i);
         end else begin
            pipe_in[i].x = s.x + (s.y >>> i);
            pipe_in[i].y = s.y - (s.x >>> i);
            pipe_in[i].z = s.z + wtgt_pkg::atan_entry(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < wtgt_pkg::CordicSteps; i++) begin
         if (reset) begin
            pipe_ff[i].valid <= 1'b0;
         end else if (advance) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   assign stage_out = pipe_ff[wtgt_pkg::CordicSteps-1];

endmodule
